// ===== src/s2c_pkg.sv =====
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared constants, tables and types of the spherical to Cartesian converter.
// ----------------------------------------------------------------------------
package s2c_pkg;

  // Number of CORDIC iterations and width of the sine and cosine words.
  localparam int CORDIC_STEPS = 16;
  localparam int DATA_WIDTH   = 16;

  // Sine and cosine carry FRAC_BITS fraction bits.
  localparam int FRAC_BITS = DATA_WIDTH - 2;

  // Port widths, fixed by the item formats.
  localparam int RW  = 16;   // radius
  localparam int AIW = 16;   // input angle
  localparam int OW  = 17;   // coordinate

  // Internal widths: rotation vector, residual angle (2^31 = pi),
  // first products and radius products.
  localparam int XW = DATA_WIDTH + 2;
  localparam int AW = 34;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int QW = RW + 1 + DATA_WIDTH;

  localparam int OUT_LIMIT = 65535;

  // Pipeline layout: fold, one stage per iteration, flip and clamp,
  // then three multiply and round stages.
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int NSTG       = CORDIC_LAT + 3;

  // Inverse CORDIC gain in Q32 and the rounded start vector.
  localparam longint unsigned INV_GAIN_Q32 = 64'd2608131497;
  localparam logic signed [XW-1:0] X_START =
    XW'((INV_GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [XW-1:0] TRIG_ONE = XW'(1) <<< FRAC_BITS;

  // atan(2^-i) with 2^31 = pi, truncated.
  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // Stage enables and stage valid bits, one bit per pipeline stage.
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctrl_t;

  // Clamped cosine and sine of one angle.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] cos_v;
    logic signed [DATA_WIDTH-1:0] sin_v;
  } trig_t;

endpackage

// ===== src/s2c_sph_if.sv =====
// ----------------------------------------------------------------------------
// s2c_sph_if
// Channel carrying one point in spherical form per item.
// ----------------------------------------------------------------------------
interface s2c_sph_if;
  logic                     valid;
  logic                     ready;
  logic [15:0]              radius;
  logic signed [15:0]       polar_angle;
  logic signed [15:0]       azimuth_angle;

  modport source (output valid, output radius, output polar_angle,
                  output azimuth_angle, input ready);
  modport sink   (input valid, input radius, input polar_angle,
                  input azimuth_angle, output ready);
endinterface

// ===== src/s2c_cart_if.sv =====
// ----------------------------------------------------------------------------
// s2c_cart_if
// Channel carrying one point in Cartesian form per item.
// ----------------------------------------------------------------------------
interface s2c_cart_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] x_coord;
  logic signed [16:0] y_coord;
  logic signed [16:0] z_coord;

  modport source (output valid, output x_coord, output y_coord,
                  output z_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord,
                  input z_coord, output ready);
endinterface

// ===== src/spherical_to_cartesian_convert_unit.sv =====
// ----------------------------------------------------------------------------
// spherical_to_cartesian_convert_unit
// Streaming conversion of spherical points to Cartesian coordinates.
// ----------------------------------------------------------------------------
// The sph channel takes one item per point: an unsigned radius and two signed
// angles, the polar angle theta and the azimuth phi, where 32768 stands for pi.
// The cart channel returns one item per point with x = r sin(theta) cos(phi),
// y = r sin(theta) sin(phi) and z = r cos(theta), rounded to nearest and
// saturated to plus or minus 65535. Both channels use valid and ready; an item
// moves at a clock edge where both are high.
// Each angle runs through its own CORDIC pipeline of one stage per iteration,
// framed by a fold stage and a clamp stage; three multiply and round stages
// follow. One item can enter in every cycle while the receiver keeps ready
// high or the last stage holds no finished item.
// When the receiver holds ready low, the finished item waits in the output
// register and the pipeline stops in place; the first stage still takes one
// more item if it is empty. Synchronous reset on rst clears all valid bits;
// the data registers keep whatever they held.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_convert_unit (
  input  logic              clk,
  input  logic              rst,
  s2c_sph_if.sink           sph,
  s2c_cart_if.source        cart
);

  localparam int LAT = s2c_pkg::CORDIC_LAT;

  s2c_pkg::pipe_ctrl_t ctrl;
  s2c_pkg::trig_t      trig_polar;
  s2c_pkg::trig_t      trig_azim;

  // Handshake and stage enables for the whole pipe.
  s2c_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sph.valid),
    .in_ready  (sph.ready),
    .out_valid (cart.valid),
    .out_ready (cart.ready),
    .ctrl      (ctrl)
  );

  // Sine and cosine of theta and of phi, side by side.
  s2c_cordic u_cordic_polar (
    .clk   (clk),
    .ctrl  (ctrl),
    .angle (sph.polar_angle),
    .trig  (trig_polar)
  );

  s2c_cordic u_cordic_azim (
    .clk   (clk),
    .ctrl  (ctrl),
    .angle (sph.azimuth_angle),
    .trig  (trig_azim)
  );

  // The radius rides along the CORDIC stages so it meets its own angles.
  logic [s2c_pkg::RW-1:0] r_dly [LAT];

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      r_dly[0] <= sph.radius;
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (ctrl.en[k]) begin
        r_dly[k] <= r_dly[k-1];
      end
    end
  end

  s2c_mult u_mult (
    .clk     (clk),
    .ctrl    (ctrl),
    .radius  (r_dly[LAT-1]),
    .polar   (trig_polar),
    .azim    (trig_azim),
    .x_coord (cart.x_coord),
    .y_coord (cart.y_coord),
    .z_coord (cart.z_coord)
  );

endmodule

// ===== src/s2c_ctrl.sv =====
// ----------------------------------------------------------------------------
// s2c_ctrl
// Valid bits and stage enables of the conversion pipeline.
// ----------------------------------------------------------------------------
module s2c_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output s2c_pkg::pipe_ctrl_t    ctrl
);

  logic [s2c_pkg::NSTG-1:0] vld;
  logic                     en_all;

  // The whole pipe moves unless the last stage holds an untaken item.
  // The first stage may still fill a bubble while the rest is stalled.
  assign en_all    = !vld[s2c_pkg::NSTG-1] || out_ready;
  assign in_ready  = en_all || !vld[0];
  assign out_valid = vld[s2c_pkg::NSTG-1];

  assign ctrl.en  = {{(s2c_pkg::NSTG-1){en_all}}, in_ready};
  assign ctrl.vld = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (in_ready) begin
        vld[0] <= in_valid;
      end
      if (en_all) begin
        vld[s2c_pkg::NSTG-1:1] <= vld[s2c_pkg::NSTG-2:0];
      end
    end
  end

endmodule

// ===== src/s2c_cordic.sv =====
// ----------------------------------------------------------------------------
// s2c_cordic
// Pipelined rotation CORDIC giving the clamped cosine and sine of one angle.
// ----------------------------------------------------------------------------
module s2c_cordic (
  input  logic                      clk,
  input  s2c_pkg::pipe_ctrl_t       ctrl,
  input  logic signed [15:0]        angle,
  output s2c_pkg::trig_t            trig
);

  localparam int N  = s2c_pkg::CORDIC_STEPS;
  localparam int AW = s2c_pkg::AW;
  localparam int XW = s2c_pkg::XW;
  localparam int DW = s2c_pkg::DATA_WIDTH;

  localparam logic signed [15:0]   QUARTER_IN = 16'sd16384;
  localparam logic signed [AW-1:0] HALF_TURN  = {{(AW-32){1'b0}}, 32'h8000_0000};

  logic signed [AW-1:0] ang_q  [N+1];
  logic signed [XW-1:0] xq     [N+1];
  logic signed [XW-1:0] yq     [N+1];
  logic                 flip_q [N+1];

  logic signed [AW-1:0] ang_ext;
  logic signed [AW-1:0] ang_fold;
  logic                 flip_fold;

  // Fold the angle into the half turn around zero; the flip negates later.
  always_comb begin
    ang_ext   = {{(AW-32){angle[15]}}, angle, 16'h0000};
    ang_fold  = ang_ext;
    flip_fold = 1'b0;
    if (angle > QUARTER_IN) begin
      ang_fold  = ang_ext - HALF_TURN;
      flip_fold = 1'b1;
    end else if (angle < -QUARTER_IN) begin
      ang_fold  = ang_ext + HALF_TURN;
      flip_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ang_q[0]  <= ang_fold;
      flip_q[0] <= flip_fold;
      xq[0]     <= s2c_pkg::X_START;
      yq[0]     <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [AW-1:0] atan;

    assign dx   = yq[i] >>> i;
    assign dy   = xq[i] >>> i;
    assign atan = $signed({{(AW-32){1'b0}}, s2c_pkg::ATAN_TABLE[i]});

    always_ff @(posedge clk) begin
      if (ctrl.en[i+1]) begin
        flip_q[i+1] <= flip_q[i];
        if (!ang_q[i][AW-1]) begin
          xq[i+1]    <= xq[i] - dx;
          yq[i+1]    <= yq[i] + dy;
          ang_q[i+1] <= ang_q[i] - atan;
        end else begin
          xq[i+1]    <= xq[i] + dx;
          yq[i+1]    <= yq[i] - dy;
          ang_q[i+1] <= ang_q[i] + atan;
        end
      end
    end
  end

  logic signed [XW-1:0] fx;
  logic signed [XW-1:0] fy;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;

  // Undo the fold, then clamp the overshoot of the rotation to plus or minus one.
  always_comb begin
    fx = flip_q[N] ? -xq[N] : xq[N];
    fy = flip_q[N] ? -yq[N] : yq[N];
    cx = fx;
    cy = fy;
    if (fx > s2c_pkg::TRIG_ONE) begin
      cx = s2c_pkg::TRIG_ONE;
    end else if (fx < -s2c_pkg::TRIG_ONE) begin
      cx = -s2c_pkg::TRIG_ONE;
    end
    if (fy > s2c_pkg::TRIG_ONE) begin
      cy = s2c_pkg::TRIG_ONE;
    end else if (fy < -s2c_pkg::TRIG_ONE) begin
      cy = -s2c_pkg::TRIG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[N+1]) begin
      trig.cos_v <= DW'(cx);
      trig.sin_v <= DW'(cy);
    end
  end

endmodule

// ===== src/s2c_mult.sv =====
// ----------------------------------------------------------------------------
// s2c_mult
// Products of the trigonometric terms with the radius, rounding and saturation.
// ----------------------------------------------------------------------------
module s2c_mult (
  input  logic                        clk,
  input  s2c_pkg::pipe_ctrl_t         ctrl,
  input  logic [s2c_pkg::RW-1:0]      radius,
  input  s2c_pkg::trig_t              polar,
  input  s2c_pkg::trig_t              azim,
  output logic signed [s2c_pkg::OW-1:0] x_coord,
  output logic signed [s2c_pkg::OW-1:0] y_coord,
  output logic signed [s2c_pkg::OW-1:0] z_coord
);

  localparam int S1 = s2c_pkg::CORDIC_LAT;
  localparam int DW = s2c_pkg::DATA_WIDTH;
  localparam int PW = s2c_pkg::PW;
  localparam int QW = s2c_pkg::QW;
  localparam int RW = s2c_pkg::RW;
  localparam int OW = s2c_pkg::OW;
  localparam int F  = s2c_pkg::FRAC_BITS;

  localparam logic signed [PW:0] HALF_P = (PW+1)'(1) <<< (F-1);
  localparam logic signed [QW:0] HALF_Q = (QW+1)'(1) <<< (F-1);
  localparam logic signed [QW:0] LIM    = (QW+1)'(s2c_pkg::OUT_LIMIT);

  // Round to nearest, halves upward, then saturate to the coordinate range.
  function automatic logic signed [OW-1:0] round_sat(input logic signed [QW-1:0] q);
    logic signed [QW:0] v;
    v = ($signed({q[QW-1], q}) + HALF_Q) >>> F;
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return OW'(v);
  endfunction

  logic signed [PW-1:0] p_sc;
  logic signed [PW-1:0] p_ss;
  logic signed [QW-1:0] p_z1;
  logic [RW-1:0]        r1;

  always_ff @(posedge clk) begin
    if (ctrl.en[S1]) begin
      p_sc <= polar.sin_v * azim.cos_v;
      p_ss <= polar.sin_v * azim.sin_v;
      p_z1 <= $signed({1'b0, radius}) * polar.cos_v;
      r1   <= radius;
    end
  end

  logic signed [PW:0]   sum_sc;
  logic signed [PW:0]   sum_ss;
  logic signed [DW-1:0] sc;
  logic signed [DW-1:0] ss;

  assign sum_sc = ($signed({p_sc[PW-1], p_sc}) + HALF_P) >>> F;
  assign sum_ss = ($signed({p_ss[PW-1], p_ss}) + HALF_P) >>> F;
  assign sc     = DW'(sum_sc);
  assign ss     = DW'(sum_ss);

  logic signed [QW-1:0] p_x;
  logic signed [QW-1:0] p_y;
  logic signed [QW-1:0] p_z2;

  always_ff @(posedge clk) begin
    if (ctrl.en[S1+1]) begin
      p_x  <= $signed({1'b0, r1}) * sc;
      p_y  <= $signed({1'b0, r1}) * ss;
      p_z2 <= p_z1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[S1+2]) begin
      x_coord <= round_sat(p_x);
      y_coord <= round_sat(p_y);
      z_coord <= round_sat(p_z2);
    end
  end

endmodule

// ===== src/s2c_checker.sv =====
// ----------------------------------------------------------------------------
// s2c_checker
// Port-level checks of the converter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module s2c_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [16:0] x_coord,
  input logic signed [16:0] y_coord,
  input logic signed [16:0] z_coord
);

  localparam logic signed [16:0] NEG_FULL = 17'sh10000;

  // Reset empties the pipe, so no result is offered right after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A waiting result stays offered until taken.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its coordinates.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({x_coord, y_coord, z_coord}))
    else $error("result changed while stalled");

  // Saturation keeps every coordinate symmetric about zero.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x_coord != NEG_FULL && y_coord != NEG_FULL && z_coord != NEG_FULL)
    else $error("coordinate outside saturation range");

endmodule

bind spherical_to_cartesian_convert_unit s2c_checker u_s2c_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (cart.valid),
  .out_ready (cart.ready),
  .x_coord   (cart.x_coord),
  .y_coord   (cart.y_coord),
  .z_coord   (cart.z_coord)
);

// ===== tb/spherical_to_cartesian_convert_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spherical_to_cartesian_convert_unit_test
// Streams spherical points through the converter and checks each Cartesian
// item against a bit-exact fixed-point CORDIC predictor, under random bursts
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_convert_unit_test;

  // Widths and iteration count shared with the design.
  localparam int FRAC_BITS    = s2c_pkg::FRAC_BITS;
  localparam int CORDIC_STEPS = s2c_pkg::CORDIC_STEPS;
  localparam int RW           = s2c_pkg::RW;
  localparam int AIW          = s2c_pkg::AIW;
  localparam int OW           = s2c_pkg::OW;

  // Run shape. The settle time at the end outlasts the converter's pipeline.
  localparam int RANDOM_POINTS = 1650;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  // Angle units inside the CORDIC: 2^31 stands for pi.
  localparam longint QUARTER_TURN = 64'sd1 <<< 30;
  localparam longint HALF_TURN    = 64'sd1 <<< 31;
  localparam longint TRIG_UNITY   = 64'sd1 <<< FRAC_BITS;
  localparam longint COORD_MAX    = 65535;

  // Start vector: converged inverse gain, rounded to FRAC_BITS fraction bits.
  localparam longint ROT_START =
    longint'((64'd2608131497 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  // atan(2^-i) in the same angle units, truncated.
  localparam longint ARCTAN [32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C,
    'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
    'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
    'h00000028, 'h00000014, 'h0000000A, 'h00000005,
    'h00000002, 'h00000001, 'h00000000, 'h00000000
  };

  typedef struct {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } cart_point_t;

  // One row of the directed table. Rows with a typed answer carry it; the
  // others are checked against the predictor.
  typedef struct {
    logic [RW-1:0]         radius;
    logic signed [AIW-1:0] polar;
    logic signed [AIW-1:0] azimuth;
    bit                    typed;
    int                    ex;
    int                    ey;
    int                    ez;
  } point_row_t;

  localparam int DIRECTED_ROWS = 20;

  // A zero radius gives the origin whatever the angles are. The other rows
  // hit the quarter-turn fold from both sides, minus pi, the largest angle
  // and the largest and smallest radius.
  point_row_t directed_points [DIRECTED_ROWS] = '{
    '{0,          0,      0, 1, 0, 0, 0},
    '{0,      32767, -32768, 1, 0, 0, 0},
    '{0,     -32768,  32767, 1, 0, 0, 0},
    '{0,      16384, -16384, 1, 0, 0, 0},
    '{65535,      0,      0, 0, 0, 0, 0},
    '{65535,  16384,      0, 0, 0, 0, 0},
    '{65535, -16384,  16384, 0, 0, 0, 0},
    '{65535,  16385, -16385, 0, 0, 0, 0},
    '{65535, -16385,  16385, 0, 0, 0, 0},
    '{65535,  32767,  32767, 0, 0, 0, 0},
    '{65535, -32768, -32768, 0, 0, 0, 0},
    '{65535, -32768,      0, 0, 0, 0, 0},
    '{65535,  16384, -32768, 0, 0, 0, 0},
    '{1,      16384,      0, 0, 0, 0, 0},
    '{1,       8192,   8192, 0, 0, 0, 0},
    '{32768,   8192,  -8192, 0, 0, 0, 0},
    '{65535,  16383,  16383, 0, 0, 0, 0},
    '{65535, -16383,     -1, 0, 0, 0, 0},
    '{12345,      1,     -1, 0, 0, 0, 0},
    '{65535,  24576, -24576, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst;

  s2c_sph_if  sph_ch ();
  s2c_cart_if cart_ch ();

  spherical_to_cartesian_convert_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .sph  (sph_ch),
    .cart (cart_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coordinates still owed by the converter, oldest first.
  cart_point_t owed_points [$];
  int          error_count = 0;
  int          cycle_count = 0;

  // Sender burst state: items left in the current burst, and a flag that
  // suppresses gaps for a stretch of back-to-back traffic.
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  // Every mismatch goes through here: one line, and the count goes up. The
  // printout is capped so a broken block does not flood the log.
  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want,
               cycle_count);
    end
  endtask

  // Sine and cosine of one 16-bit angle, as the rotation-mode CORDIC gives
  // them: fold into [-pi/2, pi/2], rotate, undo the fold, clamp to +-1.
  function automatic void cordic_trig(input logic signed [AIW-1:0] angle,
                                      output longint cos_q, output longint sin_q);
    longint resid;
    longint vx;
    longint vy;
    longint dx;
    longint dy;
    bit     flip;
    int     i;
    resid = longint'(angle) * 65536;
    flip  = 1'b0;
    if (resid > QUARTER_TURN) begin
      resid -= HALF_TURN;
      flip = 1'b1;
    end else if (resid < -QUARTER_TURN) begin
      resid += HALF_TURN;
      flip = 1'b1;
    end
    vx = ROT_START;
    vy = 0;
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (resid >= 0) begin
        vx -= dx;
        vy += dy;
        resid -= ARCTAN[i];
      end else begin
        vx += dx;
        vy -= dy;
        resid += ARCTAN[i];
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    cos_q = (vx > TRIG_UNITY) ? TRIG_UNITY : ((vx < -TRIG_UNITY) ? -TRIG_UNITY : vx);
    sin_q = (vy > TRIG_UNITY) ? TRIG_UNITY : ((vy < -TRIG_UNITY) ? -TRIG_UNITY : vy);
  endfunction

  // Round to nearest at FRAC_BITS, halves upward.
  function automatic longint round_frac(input longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [OW-1:0] saturate_coord(input longint v);
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end else if (v < -COORD_MAX) begin
      v = -COORD_MAX;
    end
    return v[OW-1:0];
  endfunction

  // Expected Cartesian point for one spherical input.
  function automatic cart_point_t convert_point(input logic [RW-1:0] radius,
                                                input logic signed [AIW-1:0] polar,
                                                input logic signed [AIW-1:0] azimuth);
    cart_point_t pt;
    longint      r;
    longint      cos_t;
    longint      sin_t;
    longint      cos_p;
    longint      sin_p;
    r = longint'(radius);
    cordic_trig(polar, cos_t, sin_t);
    cordic_trig(azimuth, cos_p, sin_p);
    pt.x = saturate_coord(round_frac(r * round_frac(sin_t * cos_p)));
    pt.y = saturate_coord(round_frac(r * round_frac(sin_t * sin_p)));
    pt.z = saturate_coord(round_frac(r * cos_t));
    return pt;
  endfunction

  // Present one point and hold it until the converter takes it. The
  // expectation is queued at the accepting edge.
  task automatic send_point(input logic [RW-1:0] radius,
                            input logic signed [AIW-1:0] polar,
                            input logic signed [AIW-1:0] azimuth,
                            input bit typed, input cart_point_t typed_pt);
    sph_ch.valid         <= 1'b1;
    sph_ch.radius        <= radius;
    sph_ch.polar_angle   <= polar;
    sph_ch.azimuth_angle <= azimuth;
    @(posedge clk);
    while (!sph_ch.ready) begin
      @(posedge clk);
    end
    owed_points.push_back(typed ? typed_pt : convert_point(radius, polar, azimuth));
  endtask

  // Called after each accepted item: at the end of a burst the sender may drop
  // valid for a random gap, then starts a new burst of random length.
  task automatic burst_step();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        sph_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending until the converter has returned every owed item.
  task automatic drain_results();
    sph_ch.valid <= 1'b0;
    while (owed_points.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Angles near the interesting spots: zero, the quarter-turn folds and the
  // ends of the range. The result wraps on purpose at plus pi.
  function automatic logic signed [AIW-1:0] edge_angle();
    int base;
    case ($urandom_range(0, 4))
      0:       base = 0;
      1:       base = 16384;
      2:       base = -16384;
      3:       base = 32767;
      default: base = -32768;
    endcase
    return AIW'(base + $urandom_range(0, 6) - 3);
  endfunction

  // Stimulus: reset, the directed table, then the random stream.
  initial begin
    cart_point_t typed_pt;
    logic [RW-1:0]         r;
    logic signed [AIW-1:0] th;
    logic signed [AIW-1:0] ph;
    int idx;

    rst                  <= 1'b1;
    sph_ch.valid         <= 1'b0;
    sph_ch.radius        <= '0;
    sph_ch.polar_angle   <= '0;
    sph_ch.azimuth_angle <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
      typed_pt.x = OW'(directed_points[idx].ex);
      typed_pt.y = OW'(directed_points[idx].ey);
      typed_pt.z = OW'(directed_points[idx].ez);
      send_point(directed_points[idx].radius, directed_points[idx].polar,
                 directed_points[idx].azimuth, directed_points[idx].typed, typed_pt);
      burst_step();
    end

    // Let the pipeline empty completely once before the random stream.
    drain_results();

    for (idx = 0; idx < RANDOM_POINTS; idx++) begin
      // A stretch of back-to-back items in the middle of the stream.
      no_gaps = (idx >= 1100 && idx < 1300);
      // Halfway through, the sender waits for the converter to catch up.
      if (idx == RANDOM_POINTS / 2) begin
        drain_results();
      end
      r  = RW'($urandom());
      th = AIW'($urandom());
      ph = AIW'($urandom());
      case ($urandom_range(0, 9))
        6: begin
          th = edge_angle();
          ph = edge_angle();
        end
        7: r = RW'($urandom_range(0, 15));
        8: r = RW'($urandom_range(65520, 65535));
        9: begin
          th = AIW'($urandom_range(0, 16) - 8);
          ph = edge_angle();
        end
        default: ;
      endcase
      send_point(r, th, ph, 1'b0, typed_pt);
      burst_step();
    end

    // All points are in. Wait for the last results, then give the pipeline
    // time to show anything it should not.
    sph_ch.valid <= 1'b0;
    while (owed_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_points.size() != 0) begin
      report_mismatch("items never returned", owed_points.size(), 0);
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: checks every accepted item against the oldest expectation, and
  // drives ready from a run/stall pattern of its own. Now and then it opens
  // a long window with no stalls at all.
  initial begin
    cart_point_t want;
    int  phase_left;
    bit  accepting;
    cart_ch.ready <= 1'b0;
    phase_left = 0;
    accepting  = 1'b0;
    forever begin
      @(posedge clk);
      if (cart_ch.valid && cart_ch.ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch("unexpected item, x_coord", cart_ch.x_coord, 0);
        end else begin
          want = owed_points.pop_front();
          if (cart_ch.x_coord !== want.x) begin
            report_mismatch("x_coord", cart_ch.x_coord, want.x);
          end
          if (cart_ch.y_coord !== want.y) begin
            report_mismatch("y_coord", cart_ch.y_coord, want.y);
          end
          if (cart_ch.z_coord !== want.z) begin
            report_mismatch("z_coord", cart_ch.z_coord, want.z);
          end
        end
      end
      if (phase_left == 0) begin
        accepting = !accepting;
        if (accepting) begin
          phase_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
        end else begin
          phase_left = $urandom_range(1, 8);
        end
      end
      phase_left--;
      cart_ch.ready <= accepting;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
src/s2c_pkg.sv
src/s2c_sph_if.sv
src/s2c_cart_if.sv
src/s2c_ctrl.sv
src/s2c_cordic.sv
src/s2c_mult.sv
src/spherical_to_cartesian_convert_unit.sv
src/s2c_checker.sv
tb/spherical_to_cartesian_convert_unit_test.sv
